@@ rtl/lmpwm_pkg.sv @@
package lmpwm_pkg;

    localparam int ROWS      = 8;
    localparam int COLUMNS   = 8;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int LEVEL_W   = 8;
    localparam int PIX_W     = 2 * LEVEL_W;
    localparam int MASK_BITS = 8;

    localparam logic               ACT_WRITE      = 1'b0;
    localparam logic               ACT_TICK       = 1'b1;
    localparam logic [LEVEL_W-1:0] INTENSITY_MAX  = 8'hff;
    localparam logic [LEVEL_W-1:0] INTENSITY_WRAP = 8'd1;

    typedef logic [PIX_W-1:0]                t_pixel;
    typedef logic [COLUMNS-1:0][PIX_W-1:0]   t_row_pixels;

    typedef struct packed {
        logic               action;
        logic [2:0]         pixel_row;
        logic [2:0]         pixel_column;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
    } t_in_word;

    typedef struct packed {
        logic [2:0]           row_drive;
        logic [MASK_BITS-1:0] green_mask;
        logic [MASK_BITS-1:0] red_mask;
    } t_out_word;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_pixel           data;
    } t_pix_write;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } t_row_read;

endpackage

@@ rtl/lmpwm_frame_store.sv @@
module lmpwm_frame_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lmpwm_pkg::t_pix_write i_write,
    input  lmpwm_pkg::t_row_read  i_read,
    output lmpwm_pkg::t_row_pixels o_row_pixels
);
    import lmpwm_pkg::*;

    t_row_pixels                     mem [ROWS];
    logic [ROWS-1:0][COLUMNS-1:0]    r_pix_valid;
    t_row_pixels                     r_rd_data;
    logic [COLUMNS-1:0]              r_rd_valid;

    // per-pixel write into the row-wide store, and registered read of one row
    always_ff @(posedge i_clk) begin
        if (i_write.en) begin
            mem[i_write.row][i_write.col] <= i_write.data;
        end
        if (i_read.en) begin
            r_rd_data <= mem[i_read.row];
        end
    end

    // valid bits stand in for the cleared store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= '0;
            r_rd_valid  <= '0;
        end else begin
            if (i_write.en) begin
                r_pix_valid[i_write.row][i_write.col] <= 1'b1;
            end
            if (i_read.en) begin
                r_rd_valid <= r_pix_valid[i_read.row];
            end
        end
    end

    always_comb begin
        for (int x = 0; x < COLUMNS; x++) begin
            o_row_pixels[x] = r_rd_valid[x] ? r_rd_data[x] : '0;
        end
    end

endmodule

@@ rtl/lmpwm_mask_unit.sv @@
module lmpwm_mask_unit (
    input  lmpwm_pkg::t_row_pixels                  i_row_pixels,
    input  logic [lmpwm_pkg::LEVEL_W-1:0]           i_intensity,
    output logic [lmpwm_pkg::MASK_BITS-1:0]         o_green_mask,
    output logic [lmpwm_pkg::MASK_BITS-1:0]         o_red_mask
);
    import lmpwm_pkg::*;

    for (genvar x = 0; x < MASK_BITS; x++) begin : g_col
        if (x < COLUMNS) begin : g_shown
            assign o_green_mask[x] = i_row_pixels[x][LEVEL_W-1:0] >= i_intensity;
            assign o_red_mask[x]   = i_row_pixels[x][PIX_W-1:LEVEL_W] >= i_intensity;
        end else begin : g_hidden
            assign o_green_mask[x] = 1'b0;
            assign o_red_mask[x]   = 1'b0;
        end
    end

endmodule

@@ rtl/led_matrix_pwm_row_scanner.sv @@
// Channel   Valid        Stall        Word
// input     i_in_valid   o_stall      i_in_word  (pixel write or scan tick)
// output    o_out_valid  i_stall      o_out_word (row and colour masks per tick)
//
// One word is taken every cycle while o_stall is low; a scan tick's result passes
// the registered row read of the frame store, then the registered compares.
// Pixel writes land in the store at the accepting edge and give no result.
// Reset clears the scan row, the intensity counter and the per-pixel valid bits.
// A stalled output holds; o_stall rises only when both stages are full.
module led_matrix_pwm_row_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_stall,
    input  lmpwm_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_stall,
    output lmpwm_pkg::t_out_word o_out_word
);
    import lmpwm_pkg::*;

    logic               r_s1_valid;
    logic [ROW_W-1:0]   r_s1_row;
    logic [LEVEL_W-1:0] r_s1_intensity;
    logic [ROW_W-1:0]   r_scan_row;
    logic [ROW_W-1:0]   n_scan_row;
    logic [LEVEL_W-1:0] r_intensity;
    logic [LEVEL_W-1:0] n_intensity;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               advance;
    logic               accept;
    logic               tick;
    logic               in_range;
    t_pix_write         pix_write;
    t_row_read          row_read;
    t_row_pixels        row_pixels;
    logic [MASK_BITS-1:0] green_mask;
    logic [MASK_BITS-1:0] red_mask;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !advance;
    assign accept  = i_in_valid && !o_stall;
    assign tick    = accept && (i_in_word.action == ACT_TICK);

    assign in_range = (int'(i_in_word.pixel_row) < ROWS)
                   && (int'(i_in_word.pixel_column) < COLUMNS);

    always_comb begin
        pix_write.en   = accept && (i_in_word.action == ACT_WRITE) && in_range;
        pix_write.row  = ROW_W'(i_in_word.pixel_row);
        pix_write.col  = COL_W'(i_in_word.pixel_column);
        pix_write.data = {i_in_word.red_level, i_in_word.green_level};
        row_read.en    = tick;
        row_read.row   = r_scan_row;
    end

    always_comb begin
        n_scan_row  = (int'(r_scan_row) == ROWS - 1) ? '0 : r_scan_row + 1'b1;
        n_intensity = (r_intensity == INTENSITY_MAX) ? INTENSITY_WRAP
                                                     : r_intensity + 1'b1;
    end

    lmpwm_frame_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_write      (pix_write),
        .i_read       (row_read),
        .o_row_pixels (row_pixels)
    );

    lmpwm_mask_unit u_mask (
        .i_row_pixels (row_pixels),
        .i_intensity  (r_s1_intensity),
        .o_green_mask (green_mask),
        .o_red_mask   (red_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row  <= '0;
            r_intensity <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (tick) begin
                r_scan_row  <= n_scan_row;
                r_intensity <= n_intensity;
            end
            if (tick) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_s1_row       <= r_scan_row;
            r_s1_intensity <= r_intensity;
        end
        if (advance && r_s1_valid) begin
            r_out_word.row_drive  <= 3'(r_s1_row);
            r_out_word.green_mask <= green_mask;
            r_out_word.red_mask   <= red_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_tick_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> r_s1_valid)
        else $error("accepted tick did not reach the compare stage");

    a_row_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> (r_scan_row != $past(r_scan_row)))
        else $error("scan row did not advance on a tick");

    a_intensity_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> (r_intensity != '0))
        else $error("intensity counter returned to zero");

    a_write_keeps_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !tick) |=> ($stable(r_intensity) && $stable(r_scan_row)))
        else $error("pixel write disturbed the scan state");

endmodule
